// ===== rtl/vin_pkg.sv =====
// shared constants for the voxel index to coordinates and neighbours block
`default_nettype none
package vin_pkg;

    localparam int IDX_W        = 24;
    localparam int COORD_W      = 8;
    localparam int MASK_W       = 6;
    localparam int CFG_W        = 9;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 4;
    localparam int DEF_MAX_SIDE = 256;

    // register indexes, byte address is 4 times the index
    typedef enum logic [1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    // face mask bit positions
    localparam int FACE_BOTTOM = 0;
    localparam int FACE_TOP    = 1;
    localparam int FACE_LEFT   = 2;
    localparam int FACE_RIGHT  = 3;
    localparam int FACE_FRONT  = 4;
    localparam int FACE_BACK   = 5;

endpackage
`default_nettype wire

// ===== rtl/voxel_index_neighbours.sv =====
// top level: linear voxel index to grid coordinates, face mask and neighbours
//
// usage
//   configuration: apb-style port, size_x at 0x0, size_y at 0x4, size_z at 0x8.
//   pready is always high; a size of zero acts as one, a size above MAX_SIDE
//   acts as MAX_SIDE. write sizes only while no item is in flight.
//   input channel: in_valid / in_ready with voxel_index.
//   output channel: out_valid / out_ready with coordinates, face_mask, six
//   neighbour indices and index_invalid (all other fields zero when set).
// timing
//   one item can enter every cycle while in_ready is high: an accepted item
//   passes two chains of 24 restoring divide stages, one quotient bit per
//   stage (index / width, then that quotient / length), followed by one
//   output stage for mask and neighbour adds, which drives out_valid.
// reset
//   rst_n clears every stage valid bit and sets all sizes to one.
// stall
//   when the output item is not taken the whole pipeline holds in place and
//   in_ready drops; nothing is lost or repeated. bubbles move on freely.
`default_nettype none
module voxel_index_neighbours
    import vin_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // input items
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [IDX_W-1:0]      voxel_index,
    // result items
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [COORD_W-1:0]    coord_x,
    output logic      [COORD_W-1:0]    coord_y,
    output logic      [COORD_W-1:0]    coord_z,
    output logic      [MASK_W-1:0]     face_mask,
    output logic      [IDX_W-1:0]      below_index,
    output logic      [IDX_W-1:0]      above_index,
    output logic      [IDX_W-1:0]      left_index,
    output logic      [IDX_W-1:0]      right_index,
    output logic      [IDX_W-1:0]      front_index,
    output logic      [IDX_W-1:0]      back_index,
    output logic                       index_invalid
);

    localparam int SIDE_W    = $clog2(MAX_SIDE + 1);   // effective size width
    localparam int RW        = $clog2(MAX_SIDE);       // remainder width
    localparam int TW        = RW + 1;                 // trial width
    localparam int LAYER_W   = 2 * SIDE_W;
    localparam int STEPS     = IDX_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    reg_idx_t         cfg_sel;
    logic             cfg_wr;

    assign cfg_sel = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= CFG_W'(1);
            size_y_reg <= CFG_W'(1);
            size_z_reg <= CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_SIZE_X: size_x_reg <= pwdata[CFG_W-1:0];
                REG_SIZE_Y: size_y_reg <= pwdata[CFG_W-1:0];
                REG_SIZE_Z: size_z_reg <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_SIZE_X: prdata = APB_DATA_W'(size_x_reg);
            REG_SIZE_Y: prdata = APB_DATA_W'(size_y_reg);
            REG_SIZE_Z: prdata = APB_DATA_W'(size_z_reg);
            default:    prdata = '0;
        endcase
    end

    // zero acts as one, clamp at the largest side
    function automatic logic [SIDE_W-1:0] eff_size(input logic [CFG_W-1:0] r);
        logic [SIDE_W-1:0] e;
        if (r == '0)
            e = SIDE_W'(1);
        else if (32'(r) > 32'(MAX_SIDE))
            e = SIDE_W'(MAX_SIDE);
        else
            e = SIDE_W'(r);
        return e;
    endfunction

    logic [SIDE_W-1:0] w_eff, h_eff, l_eff;
    assign w_eff = eff_size(size_x_reg);
    assign h_eff = eff_size(size_y_reg);
    assign l_eff = eff_size(size_z_reg);

    // one restoring divide step: bring in the dividend msb, subtract if it fits
    function automatic logic [RW+IDX_W-1:0] div_step(
        input logic [RW-1:0]     rem,
        input logic [IDX_W-1:0]  work,
        input logic [SIDE_W-1:0] d
    );
        logic [TW-1:0] trial;
        logic [TW-1:0] dd;
        logic          fits;
        trial = {rem, work[IDX_W-1]};
        dd    = TW'(d);
        fits  = (trial >= dd);
        if (fits)
            trial = trial - dd;
        return {trial[RW-1:0], work[IDX_W-2:0], fits};
    endfunction

    // ------------------------------------------------------------------
    // pipeline control: everything moves unless the output item is stuck
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // phase one: index / width, remainder is x
    // ------------------------------------------------------------------
    logic             p1_vld_reg  [1:STEPS];
    logic [IDX_W-1:0] p1_work_reg [1:STEPS];
    logic [RW-1:0]    p1_rem_reg  [1:STEPS];
    logic [IDX_W-1:0] p1_idx_reg  [1:STEPS];
    logic             p1_vld_next  [1:STEPS];
    logic [IDX_W-1:0] p1_work_next [1:STEPS];
    logic [RW-1:0]    p1_rem_next  [1:STEPS];
    logic [IDX_W-1:0] p1_idx_next  [1:STEPS];

    always_comb
    begin
        for (int s = 1; s <= STEPS; s++)
        begin
            if (s == 1)
            begin
                p1_vld_next[s] = in_valid;
                p1_idx_next[s] = voxel_index;
                {p1_rem_next[s], p1_work_next[s]} = div_step('0, voxel_index, w_eff);
            end
            else
            begin
                p1_vld_next[s] = p1_vld_reg[s-1];
                p1_idx_next[s] = p1_idx_reg[s-1];
                {p1_rem_next[s], p1_work_next[s]} =
                    div_step(p1_rem_reg[s-1], p1_work_reg[s-1], w_eff);
            end
        end
    end

    // ------------------------------------------------------------------
    // phase two: quotient / length, remainder is z, quotient is y
    // ------------------------------------------------------------------
    logic               p2_vld_reg   [1:STEPS];
    logic [IDX_W-1:0]   p2_work_reg  [1:STEPS];
    logic [RW-1:0]      p2_rem_reg   [1:STEPS];
    logic [IDX_W-1:0]   p2_idx_reg   [1:STEPS];
    logic [RW-1:0]      p2_x_reg     [1:STEPS];
    logic [LAYER_W-1:0] p2_layer_reg [1:STEPS];
    logic               p2_vld_next   [1:STEPS];
    logic [IDX_W-1:0]   p2_work_next  [1:STEPS];
    logic [RW-1:0]      p2_rem_next   [1:STEPS];
    logic [IDX_W-1:0]   p2_idx_next   [1:STEPS];
    logic [RW-1:0]      p2_x_next     [1:STEPS];
    logic [LAYER_W-1:0] p2_layer_next [1:STEPS];

    always_comb
    begin
        for (int s = 1; s <= STEPS; s++)
        begin
            if (s == 1)
            begin
                p2_vld_next[s]   = p1_vld_reg[STEPS];
                p2_idx_next[s]   = p1_idx_reg[STEPS];
                p2_x_next[s]     = p1_rem_reg[STEPS];
                p2_layer_next[s] = LAYER_W'(w_eff) * LAYER_W'(l_eff);
                {p2_rem_next[s], p2_work_next[s]} =
                    div_step('0, p1_work_reg[STEPS], l_eff);
            end
            else
            begin
                p2_vld_next[s]   = p2_vld_reg[s-1];
                p2_idx_next[s]   = p2_idx_reg[s-1];
                p2_x_next[s]     = p2_x_reg[s-1];
                p2_layer_next[s] = p2_layer_reg[s-1];
                {p2_rem_next[s], p2_work_next[s]} =
                    div_step(p2_rem_reg[s-1], p2_work_reg[s-1], l_eff);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= STEPS; s++)
            begin
                p1_vld_reg[s] <= 1'b0;
                p2_vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int s = 1; s <= STEPS; s++)
            begin
                p1_vld_reg[s] <= p1_vld_next[s];
                p2_vld_reg[s] <= p2_vld_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 1; s <= STEPS; s++)
            begin
                p1_work_reg[s]  <= p1_work_next[s];
                p1_rem_reg[s]   <= p1_rem_next[s];
                p1_idx_reg[s]   <= p1_idx_next[s];
                p2_work_reg[s]  <= p2_work_next[s];
                p2_rem_reg[s]   <= p2_rem_next[s];
                p2_idx_reg[s]   <= p2_idx_next[s];
                p2_x_reg[s]     <= p2_x_next[s];
                p2_layer_reg[s] <= p2_layer_next[s];
            end
        end
    end

    // ------------------------------------------------------------------
    // output stage: mask, neighbours, range check
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]   f_idx, f_y, f_layer, f_w, f_h;
    logic [RW-1:0]      f_x, f_z;
    logic [MASK_W-1:0]  mask_c;
    logic               bad_c;

    logic [COORD_W-1:0] coord_x_reg, coord_y_reg, coord_z_reg;
    logic [COORD_W-1:0] coord_x_next, coord_y_next, coord_z_next;
    logic [MASK_W-1:0]  face_mask_reg, face_mask_next;
    logic [IDX_W-1:0]   below_reg, above_reg, left_reg, right_reg, front_reg, back_reg;
    logic [IDX_W-1:0]   below_next, above_next, left_next, right_next, front_next, back_next;
    logic               invalid_reg, invalid_next;

    assign f_idx   = p2_idx_reg[STEPS];
    assign f_y     = p2_work_reg[STEPS];
    assign f_z     = p2_rem_reg[STEPS];
    assign f_x     = p2_x_reg[STEPS];
    assign f_layer = IDX_W'(p2_layer_reg[STEPS]);
    assign f_w     = IDX_W'(w_eff);
    assign f_h     = IDX_W'(h_eff);

    // y = index / layer, so index beyond the grid shows as y >= height
    assign bad_c = (f_y >= f_h);

    always_comb
    begin
        mask_c              = '0;
        mask_c[FACE_BOTTOM] = (f_y == '0);
        mask_c[FACE_TOP]    = (f_y == f_h - IDX_W'(1));
        mask_c[FACE_LEFT]   = (f_x == '0);
        mask_c[FACE_RIGHT]  = (SIDE_W'(f_x) == w_eff - SIDE_W'(1));
        mask_c[FACE_FRONT]  = (SIDE_W'(f_z) == l_eff - SIDE_W'(1));
        mask_c[FACE_BACK]   = (f_z == '0);

        if (bad_c)
        begin
            coord_x_next   = '0;
            coord_y_next   = '0;
            coord_z_next   = '0;
            face_mask_next = '0;
            below_next     = '0;
            above_next     = '0;
            left_next      = '0;
            right_next     = '0;
            front_next     = '0;
            back_next      = '0;
        end
        else
        begin
            coord_x_next   = COORD_W'(f_x);
            coord_y_next   = f_y[COORD_W-1:0];
            coord_z_next   = COORD_W'(f_z);
            face_mask_next = mask_c;
            below_next     = mask_c[FACE_BOTTOM] ? f_idx : f_idx - f_layer;
            above_next     = mask_c[FACE_TOP]    ? f_idx : f_idx + f_layer;
            left_next      = mask_c[FACE_LEFT]   ? f_idx : f_idx - IDX_W'(1);
            right_next     = mask_c[FACE_RIGHT]  ? f_idx : f_idx + IDX_W'(1);
            front_next     = mask_c[FACE_FRONT]  ? f_idx : f_idx + f_w;
            back_next      = mask_c[FACE_BACK]   ? f_idx : f_idx - f_w;
        end
        invalid_next = bad_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= p2_vld_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coord_x_reg   <= coord_x_next;
            coord_y_reg   <= coord_y_next;
            coord_z_reg   <= coord_z_next;
            face_mask_reg <= face_mask_next;
            below_reg     <= below_next;
            above_reg     <= above_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            front_reg     <= front_next;
            back_reg      <= back_next;
            invalid_reg   <= invalid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign coord_x       = coord_x_reg;
    assign coord_y       = coord_y_reg;
    assign coord_z       = coord_z_reg;
    assign face_mask     = face_mask_reg;
    assign below_index   = below_reg;
    assign above_index   = above_reg;
    assign left_index    = left_reg;
    assign right_index   = right_reg;
    assign front_index   = front_reg;
    assign back_index    = back_reg;
    assign index_invalid = invalid_reg;

endmodule
`default_nettype wire

// ===== rtl/vin_checker.sv =====
// port-level checks for the voxel index block and their bind
`default_nettype none
module vin_checker
    import vin_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [COORD_W-1:0] coord_x,
    input wire logic [MASK_W-1:0]  face_mask,
    input wire logic [IDX_W-1:0]   below_index,
    input wire logic [IDX_W-1:0]   left_index,
    input wire logic [IDX_W-1:0]   right_index,
    input wire logic [IDX_W-1:0]   back_index,
    input wire logic               index_invalid
);

    // a stalled result stays valid and keeps its right index and invalid flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(right_index)
            && $stable(index_invalid))
        else $error("stalled result changed");

    // input side only stalls when the result is stuck
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // an index outside the grid carries zero x, mask, below and back fields
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && index_invalid |-> coord_x == '0 && face_mask == '0
            && below_index == '0 && back_index == '0)
        else $error("invalid item with nonzero fields");

    // interior x gives left and right two apart
    a_lr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !index_invalid && !face_mask[FACE_LEFT] && !face_mask[FACE_RIGHT]
            |-> IDX_W'(right_index - left_index) == IDX_W'(2))
        else $error("left and right neighbours inconsistent");

endmodule

bind voxel_index_neighbours vin_checker u_vin_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .coord_x       (coord_x),
    .face_mask     (face_mask),
    .below_index   (below_index),
    .left_index    (left_index),
    .right_index   (right_index),
    .back_index    (back_index),
    .index_invalid (index_invalid)
);
`default_nettype wire

// ===== tb/sv/tb_voxel_index_neighbours.sv =====
// self-checking testbench for the voxel index to coordinates and neighbours block
`timescale 1ns / 100ps
`default_nettype none
module tb_voxel_index_neighbours;
    import vin_pkg::*;

    // one result item as the block presents it
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cz;
        logic [MASK_W-1:0]  mask;
        logic [IDX_W-1:0]   below;
        logic [IDX_W-1:0]   above;
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
        logic [IDX_W-1:0]   front;
        logic [IDX_W-1:0]   back;
        logic               invalid;
    } voxel_info_t;

    // directed row: sizes, index, and optionally a typed-in expected result
    typedef struct {
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        logic [CFG_W-1:0] l;
        logic [IDX_W-1:0] idx;
        bit               typed;
        voxel_info_t      result;
    } directed_row_t;

    localparam int LATENCY = 49;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [IDX_W-1:0]      voxel_index = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    voxel_info_t           got;

    // predictor copy of the size registers, raw 9-bit values
    logic [CFG_W-1:0] grid_w_reg = 9'd1;
    logic [CFG_W-1:0] grid_h_reg = 9'd1;
    logic [CFG_W-1:0] grid_l_reg = 9'd1;

    voxel_info_t pending_info[$];
    int          error_count = 0;
    bit          stim_done = 1'b0;

    always #2 clk = ~clk;

    voxel_index_neighbours u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .voxel_index  (voxel_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coord_x      (got.cx),
        .coord_y      (got.cy),
        .coord_z      (got.cz),
        .face_mask    (got.mask),
        .below_index  (got.below),
        .above_index  (got.above),
        .left_index   (got.left),
        .right_index  (got.right),
        .front_index  (got.front),
        .back_index   (got.back),
        .index_invalid(got.invalid)
    );

    // a zero size acts as one, anything above the max side is clamped
    function automatic longint unsigned clamp_side(logic [CFG_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > DEF_MAX_SIDE)
            return DEF_MAX_SIDE;
        return r;
    endfunction

    // coordinates, touched faces and neighbour indices of one voxel
    function automatic voxel_info_t locate_voxel(logic [IDX_W-1:0] idx);
        longint unsigned w, h, l, layer, i, x, y, z;
        voxel_info_t     r;
        w     = clamp_side(grid_w_reg);
        h     = clamp_side(grid_h_reg);
        l     = clamp_side(grid_l_reg);
        layer = w * l;
        i     = idx;
        r     = '0;
        if (i >= layer * h)
        begin
            r.invalid = 1'b1;
            return r;
        end
        x = i % w;
        z = (i / w) % l;
        y = (i / layer) % h;
        r.mask[FACE_BOTTOM] = (y == 0);
        r.mask[FACE_TOP]    = (y == h - 1);
        r.mask[FACE_LEFT]   = (x == 0);
        r.mask[FACE_RIGHT]  = (x == w - 1);
        r.mask[FACE_FRONT]  = (z == l - 1);
        r.mask[FACE_BACK]   = (z == 0);
        r.cx    = x[COORD_W-1:0];
        r.cy    = y[COORD_W-1:0];
        r.cz    = z[COORD_W-1:0];
        r.below = r.mask[FACE_BOTTOM] ? idx : IDX_W'(i - layer);
        r.above = r.mask[FACE_TOP]    ? idx : IDX_W'(i + layer);
        r.left  = r.mask[FACE_LEFT]   ? idx : IDX_W'(i - 1);
        r.right = r.mask[FACE_RIGHT]  ? idx : IDX_W'(i + 1);
        r.front = r.mask[FACE_FRONT]  ? idx : IDX_W'(i + w);
        r.back  = r.mask[FACE_BACK]   ? idx : IDX_W'(i - w);
        return r;
    endfunction

    // apb write, setup then access, data lands on the access edge
    task automatic write_reg(reg_idx_t ri, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * int'(ri));
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (ri)
            REG_SIZE_X: grid_w_reg = value[CFG_W-1:0];
            REG_SIZE_Y: grid_h_reg = value[CFG_W-1:0];
            REG_SIZE_Z: grid_l_reg = value[CFG_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // wait for an empty pipeline, then reprogram all three sizes
    task automatic set_grid(logic [APB_DATA_W-1:0] w, logic [APB_DATA_W-1:0] h,
                            logic [APB_DATA_W-1:0] l);
        int guard;
        guard = 0;
        while (pending_info.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        write_reg(REG_SIZE_X, w);
        write_reg(REG_SIZE_Y, h);
        write_reg(REG_SIZE_Z, l);
    endtask

    // present one item, hold it until taken; the gap comes first
    task automatic send_voxel(logic [IDX_W-1:0] idx, bit typed, voxel_info_t result);
        int gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        voxel_index <= idx;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_info.push_back(typed ? result : locate_voxel(idx));
        @(negedge clk);
    endtask

    // random index: mostly inside the current grid, some beyond it
    function automatic logic [IDX_W-1:0] pick_index();
        longint unsigned total;
        total = clamp_side(grid_w_reg) * clamp_side(grid_h_reg) * clamp_side(grid_l_reg);
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom);
            1: return IDX_W'(total);
            2: return IDX_W'(total - 1);
            default: return IDX_W'($urandom % total);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_side();
        case ($urandom_range(0, 7))
            0: return 9'd0;
            1: return 9'd256;
            2: return CFG_W'($urandom_range(257, 511));
            3: return 9'd1;
            4: return CFG_W'($urandom_range(200, 256));
            default: return CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    // result side: random stalls, compare with the oldest expectation
    initial
    begin : sink
        int          stall;
        voxel_info_t want;
        forever
        begin
            @(negedge clk);
            stall = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            if (pending_info.size() == 0)
            begin
                $display("%0t: unexpected result item %p", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_info.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    directed_row_t directed_rows[] = '{
        // after reset the grid is one voxel
        '{9'd1,   9'd1,   9'd1,   24'd0, 1'b1,
          '{8'd0, 8'd0, 8'd0, 6'h3F, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 1'b0}},
        '{9'd1,   9'd1,   9'd1,   24'd1, 1'b1, '{default: '0, invalid: 1'b1}},
        '{9'd1,   9'd1,   9'd1,   24'hFFFFFF, 1'b1, '{default: '0, invalid: 1'b1}},
        // ordinary grid: corners, a right-face voxel and the first index beyond it
        '{9'd4,   9'd3,   9'd5,   24'd0,  1'b0, '{default: '0}},
        '{9'd4,   9'd3,   9'd5,   24'd27, 1'b0, '{default: '0}},
        '{9'd4,   9'd3,   9'd5,   24'd59, 1'b0, '{default: '0}},
        '{9'd4,   9'd3,   9'd5,   24'd60, 1'b1, '{default: '0, invalid: 1'b1}},
        // zero sizes act as one
        '{9'd0,   9'd0,   9'd7,   24'd3,  1'b0, '{default: '0}},
        '{9'd0,   9'd0,   9'd0,   24'd0,  1'b0, '{default: '0}},
        // oversize clamps to the max side, then the full 256 grid up to coordinates 255
        '{9'd511, 9'd300, 9'd257, 24'hFFFFFF, 1'b0, '{default: '0}},
        '{9'd256, 9'd256, 9'd256, 24'hFFFFFE, 1'b0, '{default: '0}},
        '{9'd256, 9'd256, 9'd256, 24'h808080, 1'b0, '{default: '0}},
        '{9'd256, 9'd256, 9'd256, 24'h7F7F7F, 1'b0, '{default: '0}},
        '{9'd256, 9'd256, 9'd256, 24'h000100, 1'b0, '{default: '0}},
        // thin grids
        '{9'd1,   9'd256, 9'd1,   24'd128, 1'b0, '{default: '0}},
        '{9'd255, 9'd2,   9'd3,   24'd1529, 1'b0, '{default: '0}},
        '{9'd255, 9'd2,   9'd3,   24'd1530, 1'b1, '{default: '0, invalid: 1'b1}}
    };

    initial
    begin : stimulus
        int n;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // a write to the unused register index must leave the sizes alone
        write_reg(REG_NONE, 32'd17);
        foreach (directed_rows[k])
        begin
            if (directed_rows[k].w != grid_w_reg || directed_rows[k].h != grid_h_reg ||
                directed_rows[k].l != grid_l_reg)
            begin
                // pipeline drained before the sizes change
                in_valid <= 1'b0;
                set_grid(directed_rows[k].w, directed_rows[k].h, directed_rows[k].l);
            end
            send_voxel(directed_rows[k].idx, directed_rows[k].typed,
                       directed_rows[k].result);
        end

        // random phases, each with fresh sizes; upper pwdata bits are noise
        n = 0;
        while (n < 1950)
        begin
            in_valid <= 1'b0;
            set_grid(APB_DATA_W'({$urandom, pick_side()}),
                     APB_DATA_W'({$urandom, pick_side()}),
                     APB_DATA_W'({$urandom, pick_side()}));
            repeat ($urandom_range(20, 150))
            begin
                send_voxel(pick_index(), 1'b0, '{default: '0});
                n++;
            end
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // end of run: drain, let the pipeline settle, then report
    initial
    begin : finisher
        wait (stim_done);
        while (pending_info.size() != 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        if (error_count == 0 && pending_info.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial
    begin : watchdog
        #(4ns * 400000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/vin_pkg.sv
rtl/voxel_index_neighbours.sv
rtl/vin_checker.sv
tb/sv/tb_voxel_index_neighbours.sv
